// ----- design/lsws_pkg.sv -----
// shared types and codes for the lifo stack with search
`timescale 1ns / 1ps

package lsws_pkg;

  localparam logic [2:0] OP_PUSH        = 3'd0;
  localparam logic [2:0] OP_POP         = 3'd1;
  localparam logic [2:0] OP_PUSH_LESS   = 3'd2;
  localparam logic [2:0] OP_PUSH_UNIQUE = 3'd3;
  localparam logic [2:0] OP_CONTAINS    = 3'd4;
  localparam logic [2:0] OP_CLEAR       = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_POP_RD
  } state_t;

  typedef struct packed {
    logic [2:0]          func;
    logic signed [31:0]  operand;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  top_value;
    logic [6:0]          depth_used;
    logic                is_empty;
    logic                found;
    logic [1:0]          status;
  } out_item_t;

endpackage

// ----- design/lsws_ram.sv -----
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module lsws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/lsws_ctrl.sv -----
// stack sequencer: fill count, cached top entry, search walk over the ram
`timescale 1ns / 1ps

module lsws_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  lsws_pkg::in_item_t       in_data,
  input  logic                     out_free,
  output logic                     done,
  output lsws_pkg::out_item_t      result,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [31:0]              mem_wdata,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [31:0]              mem_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lsws_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic signed [31:0] top_r, top_nxt;
  logic [2:0]         op_r, op_nxt;
  logic [31:0]        operand_r, operand_nxt;
  logic               res_found;
  logic [1:0]         res_status;
  logic               is_full;
  logic [CW-1:0]      pop_addr;
  logic               hit;
  logic [CW+6:0]      count_ext;

  assign is_full   = (count_r == CW'(DEPTH));
  assign pop_addr  = CW'(count_r - CW'(2));
  assign hit       = (mem_rdata == operand_r);
  assign count_ext = {7'd0, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsws_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    top_r     <= top_nxt;
    op_r      <= op_nxt;
    operand_r <= operand_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    top_nxt     = top_r;
    op_nxt      = op_r;
    operand_nxt = operand_r;
    in_ready    = 1'b0;
    done        = 1'b0;
    res_found   = 1'b0;
    res_status  = lsws_pkg::STAT_OK;
    mem_we      = 1'b0;
    mem_waddr   = count_r[AW-1:0];
    mem_wdata   = in_data.operand;
    mem_raddr   = '0;

    case (state_r)
      lsws_pkg::ST_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          op_nxt      = in_data.func;
          operand_nxt = in_data.operand;
          case (in_data.func)
            lsws_pkg::OP_PUSH: begin
              done = 1'b1;
              if (is_full) begin
                res_status = lsws_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = CW'(count_r + 1'b1);
                top_nxt   = in_data.operand;
              end
            end
            lsws_pkg::OP_POP: begin
              if (count_r == '0) begin
                done       = 1'b1;
                res_status = lsws_pkg::STAT_EMPTY;
              end else if (count_r == CW'(1)) begin
                done      = 1'b1;
                count_nxt = '0;
              end else begin
                count_nxt = CW'(count_r - 1'b1);
                mem_raddr = pop_addr[AW-1:0];
                state_nxt = lsws_pkg::ST_POP_RD;
              end
            end
            lsws_pkg::OP_PUSH_LESS: begin
              done = 1'b1;
              if (count_r == '0) begin
                res_status = lsws_pkg::STAT_EMPTY;
              end else if (top_r > in_data.operand) begin
                if (is_full) begin
                  res_status = lsws_pkg::STAT_FULL;
                end else begin
                  mem_we    = 1'b1;
                  count_nxt = CW'(count_r + 1'b1);
                  top_nxt   = in_data.operand;
                end
              end
            end
            lsws_pkg::OP_PUSH_UNIQUE: begin
              if (count_r == '0) begin
                done      = 1'b1;
                mem_we    = 1'b1;
                count_nxt = CW'(1);
                top_nxt   = in_data.operand;
              end else begin
                mem_raddr = '0;
                idx_nxt   = CW'(1);
                state_nxt = lsws_pkg::ST_SEARCH;
              end
            end
            lsws_pkg::OP_CONTAINS: begin
              if (count_r == '0) begin
                done       = 1'b1;
                res_status = lsws_pkg::STAT_EMPTY;
              end else begin
                mem_raddr = '0;
                idx_nxt   = CW'(1);
                state_nxt = lsws_pkg::ST_SEARCH;
              end
            end
            lsws_pkg::OP_CLEAR: begin
              done      = 1'b1;
              count_nxt = '0;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      lsws_pkg::ST_POP_RD: begin
        done      = 1'b1;
        top_nxt   = mem_rdata;
        state_nxt = lsws_pkg::ST_IDLE;
      end
      lsws_pkg::ST_SEARCH: begin
        mem_wdata = operand_r;
        if (hit || idx_r == count_r) begin
          done      = 1'b1;
          res_found = hit;
          state_nxt = lsws_pkg::ST_IDLE;
          if (op_r == lsws_pkg::OP_PUSH_UNIQUE && !hit) begin
            if (is_full) begin
              res_status = lsws_pkg::STAT_FULL;
            end else begin
              mem_we    = 1'b1;
              count_nxt = CW'(count_r + 1'b1);
              top_nxt   = operand_r;
            end
          end
        end else begin
          mem_raddr = idx_r[AW-1:0];
          idx_nxt   = CW'(idx_r + 1'b1);
        end
      end
      default: begin
        state_nxt = lsws_pkg::ST_IDLE;
      end
    endcase

    result.top_value  = (count_nxt == '0) ? 32'sd0 : top_nxt;
    result.depth_used = count_ext[6:0];
    result.is_empty   = (count_nxt == '0);
    result.found      = res_found;
    result.status     = res_status;
  end

endmodule

// ----- design/lifo_stack_with_search_core.sv -----
// lifo stack with membership search: top level, output register and checks
// push, push-if-less, clear and unused codes finish in the accept cycle
// pop reads the new top from the ram in ST_POP_RD; an empty or emptied stack ends it at accept
// contains and push-unique compare k entries (k <= fill count) in ST_SEARCH, one per cycle
// throughput: one item at a time; the next is taken as the result register frees
// reset: fill count and sequencer cleared; ram contents are not cleared and need no sweep
`timescale 1ns / 1ps

module lifo_stack_with_search_core #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lsws_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lsws_pkg::out_item_t  out_data
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic                 out_valid_r;
  lsws_pkg::out_item_t  out_data_r;
  logic                 out_free;
  logic                 done;
  lsws_pkg::out_item_t  result;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [31:0]          mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [31:0]          mem_rdata;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  lsws_ctrl #(
    .DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_free  (out_free),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  lsws_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= result;
    end
  end

  a_accept_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> out_free)
    else $error("input transfer while result register busy");

  a_done_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> out_free)
    else $error("result produced over a pending result");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == lsws_pkg::STAT_FULL) |-> !out_data_r.is_empty)
    else $error("full status reported on empty stack");

  a_empty_zero_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.is_empty) |->
      (out_data_r.top_value == 32'sd0 && !out_data_r.found))
    else $error("empty stack reports a top or a hit");

endmodule

// ----- verif/lsws_checker.sv -----
// transfer monitor and result predictor for the lifo stack with search
`timescale 1ns / 1ps

module lsws_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  lsws_pkg::in_item_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  lsws_pkg::out_item_t  out_data,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen
);

  logic signed [31:0]  stack_words [STACK_DEPTH];
  int                  stack_fill = 0;
  lsws_pkg::out_item_t expected_results [$];
  int                  mismatch_total = 0;
  int                  result_total = 0;
  int                  queued_total = 0;

  assign fail_count   = mismatch_total;
  assign pending      = queued_total;
  assign results_seen = result_total;

  function automatic logic [1:0] push_word(input logic signed [31:0] value);
    if (stack_fill >= STACK_DEPTH) return lsws_pkg::STAT_FULL;
    stack_words[stack_fill] = value;
    stack_fill++;
    return lsws_pkg::STAT_OK;
  endfunction

  function automatic logic stack_holds(input logic signed [31:0] value);
    for (int i = 0; i < stack_fill; i++) begin
      if (stack_words[i] == value) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic lsws_pkg::out_item_t stack_step(input lsws_pkg::in_item_t item);
    lsws_pkg::out_item_t res;
    logic [1:0]          stat;
    logic                hit;
    stat = lsws_pkg::STAT_OK;
    hit  = 1'b0;
    case (item.func)
      lsws_pkg::OP_PUSH: begin
        stat = push_word(item.operand);
      end
      lsws_pkg::OP_POP: begin
        if (stack_fill == 0) stat = lsws_pkg::STAT_EMPTY;
        else stack_fill--;
      end
      lsws_pkg::OP_PUSH_LESS: begin
        if (stack_fill == 0) stat = lsws_pkg::STAT_EMPTY;
        else if ($signed(item.operand) < $signed(stack_words[stack_fill-1]))
          stat = push_word(item.operand);
      end
      lsws_pkg::OP_PUSH_UNIQUE: begin
        if (stack_holds(item.operand)) hit = 1'b1;
        else stat = push_word(item.operand);
      end
      lsws_pkg::OP_CONTAINS: begin
        if (stack_fill == 0) stat = lsws_pkg::STAT_EMPTY;
        else hit = stack_holds(item.operand);
      end
      lsws_pkg::OP_CLEAR: begin
        stack_fill = 0;
      end
      default: begin
      end
    endcase
    res.top_value  = (stack_fill != 0) ? stack_words[stack_fill-1] : 32'sd0;
    res.depth_used = 7'(stack_fill);
    res.is_empty   = (stack_fill == 0);
    res.found      = hit;
    res.status     = stat;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatch_total++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    lsws_pkg::out_item_t want;
    lsws_pkg::out_item_t got;
    if (!rst_n) begin
      stack_fill = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        result_total++;
        if (expected_results.size() == 0) begin
          mismatch_total++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        end else begin
          want = expected_results.pop_front();
          check_field("top_value", want.top_value, got.top_value);
          check_field("depth_used", 32'(want.depth_used), 32'(got.depth_used));
          check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
          check_field("found", 32'(want.found), 32'(got.found));
          check_field("status", 32'(want.status), 32'(got.status));
        end
      end
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(), stack_step(in_data));
    end
    queued_total = expected_results.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// testbench top for the lifo stack with search: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int         DEPTH        = 64;
  localparam int         ITEM_TARGET  = 700;
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         DRAIN_CYCLES = 100;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         HOLD_AFTER   = 150;
  localparam logic [2:0] FUNC_SPARE_A = 3'd6;
  localparam logic [2:0] FUNC_SPARE_B = 3'd7;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  lsws_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  lsws_pkg::out_item_t out_data;
  int                  fail_count;
  int                  pending;
  int                  results_seen;
  int                  cycle_count = 0;
  logic [31:0]         recent_vals [$];

  lifo_stack_with_search_core #(.STACK_DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lsws_checker #(.STACK_DEPTH(DEPTH)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic lsws_pkg::in_item_t make_item(input logic [2:0] func,
                                                   input logic [31:0] value);
    lsws_pkg::in_item_t item;
    item.func    = func;
    item.operand = value;
    return item;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mix of literal corners, recently used values and full random words
  function automatic logic [31:0] pick_operand();
    logic [31:0] value;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      case ($urandom_range(0, 7))
        0: value = 32'h7fff_ffff;
        1: value = 32'h8000_0000;
        2: value = 32'h0000_0000;
        3: value = 32'hffff_ffff;
        4: value = 32'h0000_0001;
        5: value = 32'h5555_5555;
        6: value = 32'haaaa_aaaa;
        default: value = 32'h0000_0002;
      endcase
    end else if (r < 55 && recent_vals.size() != 0) begin
      value = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
    end else begin
      value = $urandom;
    end
    recent_vals.insert(recent_vals.size(), value);
    if (recent_vals.size() > 16) void'(recent_vals.pop_front());
    return value;
  endfunction

  function automatic logic [2:0] pick_func(input mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 60) return lsws_pkg::OP_PUSH;
        if (r < 75) return lsws_pkg::OP_PUSH_UNIQUE;
        if (r < 85) return lsws_pkg::OP_PUSH_LESS;
        if (r < 95) return lsws_pkg::OP_CONTAINS;
        return lsws_pkg::OP_POP;
      end
      MIX_DRAIN: begin
        if (r < 55) return lsws_pkg::OP_POP;
        if (r < 70) return lsws_pkg::OP_CONTAINS;
        if (r < 82) return lsws_pkg::OP_PUSH;
        if (r < 88) return lsws_pkg::OP_PUSH_LESS;
        if (r < 94) return lsws_pkg::OP_PUSH_UNIQUE;
        if (r < 97) return lsws_pkg::OP_CLEAR;
        return r[0] ? FUNC_SPARE_A : FUNC_SPARE_B;
      end
      default: begin
        if (r < 3) return lsws_pkg::OP_CLEAR;
        if (r < 10) return r[0] ? FUNC_SPARE_A : FUNC_SPARE_B;
        case (r % 5)
          0: return lsws_pkg::OP_PUSH;
          1: return lsws_pkg::OP_POP;
          2: return lsws_pkg::OP_PUSH_LESS;
          3: return lsws_pkg::OP_PUSH_UNIQUE;
          default: return lsws_pkg::OP_CONTAINS;
        endcase
      end
    endcase
  endfunction

  task automatic send_item(input lsws_pkg::in_item_t item, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : stimulus
    mix_t mix;
    int   run_len;
    bit   quiet;
    int   sent;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stack corners, extremes, every operation and the spare codes
    send_item(make_item(lsws_pkg::OP_POP, 32'd0), pick_gap());
    send_item(make_item(lsws_pkg::OP_PUSH_LESS, 32'd5), pick_gap());
    send_item(make_item(lsws_pkg::OP_CONTAINS, 32'd5), pick_gap());
    send_item(make_item(lsws_pkg::OP_PUSH_UNIQUE, 32'd5), pick_gap());
    send_item(make_item(lsws_pkg::OP_PUSH, 32'h7fff_ffff), pick_gap());
    send_item(make_item(lsws_pkg::OP_PUSH, 32'h8000_0000), pick_gap());
    send_item(make_item(lsws_pkg::OP_PUSH_LESS, 32'd0), pick_gap());
    send_item(make_item(lsws_pkg::OP_PUSH, 32'd10), pick_gap());
    send_item(make_item(lsws_pkg::OP_PUSH_LESS, 32'd3), pick_gap());
    send_item(make_item(lsws_pkg::OP_PUSH_UNIQUE, 32'd3), pick_gap());
    send_item(make_item(lsws_pkg::OP_PUSH_UNIQUE, 32'hffff_fff9), pick_gap());
    send_item(make_item(lsws_pkg::OP_CONTAINS, 32'd5), pick_gap());
    send_item(make_item(lsws_pkg::OP_CONTAINS, 32'd1234), pick_gap());
    send_item(make_item(lsws_pkg::OP_PUSH_LESS, 32'hffff_fff9), pick_gap());
    send_item(make_item(FUNC_SPARE_A, 32'hffff_ffff), pick_gap());
    send_item(make_item(FUNC_SPARE_B, 32'h0000_0000), pick_gap());
    send_item(make_item(lsws_pkg::OP_POP, 32'd0), pick_gap());
    send_item(make_item(lsws_pkg::OP_POP, 32'd0), pick_gap());
    send_item(make_item(lsws_pkg::OP_CLEAR, 32'd0), pick_gap());
    send_item(make_item(lsws_pkg::OP_POP, 32'd0), pick_gap());
    send_item(make_item(lsws_pkg::OP_CLEAR, 32'hffff_ffff), pick_gap());
    send_item(make_item(lsws_pkg::OP_PUSH, 32'hffff_ffff), pick_gap());
    send_item(make_item(lsws_pkg::OP_PUSH, 32'h0000_0000), pick_gap());

    // runs biased toward filling, draining or mixing, some without gaps
    sent = 0;
    while (sent < ITEM_TARGET) begin
      mix     = mix_t'($urandom_range(0, 2));
      run_len = (mix == MIX_FILL) ? $urandom_range(60, 120) : $urandom_range(30, 90);
      quiet   = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < run_len && sent < ITEM_TARGET; k++) begin
        send_item(make_item(pick_func(mix), pick_operand()), quiet ? 0 : pick_gap());
        sent++;
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : receiver
    int   r;
    int   span;
    logic level;
    bit   hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        // long backpressure while the sender keeps offering
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          level = 1'b1;
          span  = $urandom_range(1, 12);
        end else if (r < 55) begin
          level = 1'b1;
          span  = $urandom_range(50, 200);
        end else if (r < 92) begin
          level = 1'b0;
          span  = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          span  = $urandom_range(10, 40);
        end
        out_ready <= level;
        repeat (span) @(posedge clk);
      end
    end
  end

endmodule
